[rtl/core/lrukv_pkg.sv]
// shared types and constants for the lru key/value cache
// no dependencies; used by lrukv_cell and lru_key_value_cache_top
package lrukv_pkg;

   localparam int ENTRIES_DEFAULT = 16;
   localparam int KEY_W = 32;
   localparam int DATA_W = 32;
   localparam int CAP_W = 5;

   localparam logic REQ_GET = 1'b0;
   localparam logic REQ_SET = 1'b1;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
   localparam logic [DATA_W-1:0] MISS_VALUE = {DATA_W{1'b1}};

   typedef struct packed {
      logic update;
      logic set_op;
      logic hit_any;
      logic [KEY_W-1:0] key;
      logic [DATA_W-1:0] data;
   } bcast_type;

endpackage

[rtl/core/lrukv_cell.sv]
// one entry of the recency-ordered row: key, data and valid bit
// depends on lrukv_pkg for the broadcast struct and field widths
module lrukv_cell #(
   parameter int INDEX = 0,
   parameter int CW = 5
) (
   input  logic clock,
   input  logic reset,
   input  lrukv_pkg::bcast_type bcast,
   input  logic [CW-1:0] new_count,
   input  logic [lrukv_pkg::KEY_W-1:0] prev_key,
   input  logic [lrukv_pkg::DATA_W-1:0] prev_data,
   input  logic prev_valid,
   input  logic seen_in,
   input  logic [lrukv_pkg::DATA_W-1:0] data_in,
   output logic [lrukv_pkg::KEY_W-1:0] key_q,
   output logic [lrukv_pkg::DATA_W-1:0] data_q,
   output logic valid_q,
   output logic seen_out,
   output logic [lrukv_pkg::DATA_W-1:0] data_out
);

   logic [lrukv_pkg::KEY_W-1:0] key_ff, key_in;
   logic [lrukv_pkg::DATA_W-1:0] data_ff, data_in_nxt;
   logic valid_ff, valid_in;
   logic match, shift;

   assign match = valid_ff & (key_ff == bcast.key);
   assign seen_out = seen_in | match;
   assign data_out = data_in | (match ? data_ff : '0);
   assign shift = bcast.update & ~seen_in & (bcast.set_op | bcast.hit_any);

   always_comb begin
      key_in = shift ? prev_key : key_ff;
      data_in_nxt = shift ? prev_data : data_ff;
      if (bcast.update & bcast.set_op) begin
         valid_in = (CW'(INDEX) < new_count);
      end else if (shift) begin
         valid_in = prev_valid;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      data_ff <= data_in_nxt;
   end

   assign key_q = key_ff;
   assign data_q = data_ff;
   assign valid_q = valid_ff;

endmodule

[rtl/core/lru_key_value_cache_top.sv]
// top level of the lru key/value cache: row of cells plus handshake and count
// depends on lrukv_pkg and lrukv_cell
//
// request channel req_*: req_type selects get or set, req_key and req_value
// carry the item; it is taken when req_valid is high and req_stall is low.
// a get gives one item on rsp_*: rsp_hit and rsp_read_value (all ones on a
// miss); a set gives none. the response is registered and appears in the
// cycle after the get is taken. one item is taken per cycle while req_stall is
// low: the key compare, the hit-data select and the one-place shift along the
// row of cells all finish in that cycle. req_stall is high only while a
// response waits with rsp_stall high; the waiting response holds until taken.
// csr_capacity sets the number of entries in use (0 acts as 1, above ENTRIES
// acts as ENTRIES); csr_ready is always high.
// reset clears all valid bits, the fill count and the response valid flag and
// sets the capacity to 16; the block is usable in the next cycle.
module lru_key_value_cache_top #(
   parameter int ENTRIES = lrukv_pkg::ENTRIES_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic req_type,
   input  logic signed [lrukv_pkg::KEY_W-1:0] req_key,
   input  logic signed [lrukv_pkg::DATA_W-1:0] req_value,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic rsp_hit,
   output logic signed [lrukv_pkg::DATA_W-1:0] rsp_read_value,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [lrukv_pkg::CAP_W-1:0] csr_capacity
);

   localparam int CW = $clog2(ENTRIES + 1);

   logic [lrukv_pkg::CAP_W-1:0] cap_ff, cap_in;
   logic [CW-1:0] count_ff, count_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_hit_ff, rsp_hit_in;
   logic [lrukv_pkg::DATA_W-1:0] rsp_value_ff, rsp_value_in;

   logic accept;
   lrukv_pkg::bcast_type bcast;
   logic [CW-1:0] cap_eff, n_rem, n_trim, new_count;

   logic [lrukv_pkg::KEY_W-1:0] key_q [ENTRIES];
   logic [lrukv_pkg::DATA_W-1:0] data_q [ENTRIES];
   logic [ENTRIES-1:0] valid_vec;
   logic [ENTRIES:0] seen;
   logic [lrukv_pkg::DATA_W-1:0] acc [ENTRIES+1];

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept = req_valid & ~req_stall;
   assign csr_ready = 1'b1;

   assign seen[0] = 1'b0;
   assign acc[0] = '0;

   always_comb begin
      bcast.update = accept;
      bcast.set_op = (req_type == lrukv_pkg::REQ_SET);
      bcast.hit_any = seen[ENTRIES];
      bcast.key = req_key;
      bcast.data = bcast.set_op ? req_value : acc[ENTRIES];
   end

   always_comb begin
      if (cap_ff == '0) begin
         cap_eff = CW'(1);
      end else if (32'(cap_ff) > 32'(ENTRIES)) begin
         cap_eff = CW'(ENTRIES);
      end else begin
         cap_eff = CW'(cap_ff);
      end
      n_rem = count_ff - CW'(seen[ENTRIES]);
      n_trim = (n_rem >= cap_eff) ? (cap_eff - CW'(1)) : n_rem;
      new_count = n_trim + CW'(1);
   end

   genvar i;
   generate
      for (i = 0; i < ENTRIES; i++) begin : g_cell
         logic [lrukv_pkg::KEY_W-1:0] pk;
         logic [lrukv_pkg::DATA_W-1:0] pd;
         logic pv;
         if (i == 0) begin : g_front
            assign pk = bcast.key;
            assign pd = bcast.data;
            assign pv = 1'b1;
         end else begin : g_rest
            assign pk = key_q[i-1];
            assign pd = data_q[i-1];
            assign pv = valid_vec[i-1];
         end
         lrukv_cell #(
            .INDEX(i),
            .CW(CW)
         ) u_cell (
            .clock(clock),
            .reset(reset),
            .bcast(bcast),
            .new_count(new_count),
            .prev_key(pk),
            .prev_data(pd),
            .prev_valid(pv),
            .seen_in(seen[i]),
            .data_in(acc[i]),
            .key_q(key_q[i]),
            .data_q(data_q[i]),
            .valid_q(valid_vec[i]),
            .seen_out(seen[i+1]),
            .data_out(acc[i+1])
         );
      end
   endgenerate

   always_comb begin
      cap_in = csr_valid ? csr_capacity : cap_ff;
      count_in = (accept & bcast.set_op) ? new_count : count_ff;
      rsp_hit_in = rsp_hit_ff;
      rsp_value_in = rsp_value_ff;
      if (accept & ~bcast.set_op) begin
         rsp_valid_in = 1'b1;
         rsp_hit_in = seen[ENTRIES];
         rsp_value_in = seen[ENTRIES] ? acc[ENTRIES] : lrukv_pkg::MISS_VALUE;
      end else if (rsp_valid_ff & ~rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= lrukv_pkg::CAP_RESET;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cap_ff <= cap_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_hit_ff <= rsp_hit_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_hit = rsp_hit_ff;
   assign rsp_read_value = rsp_value_ff;

   // fill count tracks the valid bits
   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      32'($countones(valid_vec)) == 32'(count_ff))
      else $error("fill count differs from valid bits");

   // valid entries are packed at the front of the row
   a_valid_packed: assert property (@(posedge clock) disable iff (reset)
      ((valid_vec + ENTRIES'(1)) & valid_vec) == '0)
      else $error("gap in valid entries");

   a_get_responds: assert property (@(posedge clock) disable iff (reset)
      (accept && req_type == lrukv_pkg::REQ_GET) |=> rsp_valid)
      else $error("get item gave no response");

   a_miss_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit) |-> (rsp_read_value == lrukv_pkg::MISS_VALUE))
      else $error("miss response without all-ones value");

endmodule

[dv/lru_key_value_cache_top_test.sv]
// self-checking testbench for lru_key_value_cache_top: directed and random get/set items
// depends on lrukv_pkg and the cache rtl; predicts every response with its own recency list
`timescale 1ns / 1ps

class cache_scoreboard;
   typedef struct {
      logic [lrukv_pkg::KEY_W-1:0] key;
      logic [lrukv_pkg::DATA_W-1:0] data;
   } slot_t;

   typedef struct {
      logic hit;
      logic [lrukv_pkg::DATA_W-1:0] value;
   } read_t;

   // most recent first
   slot_t recency_list[$];
   logic [lrukv_pkg::CAP_W-1:0] capacity;
   read_t expected_reads[$];
   int mismatches;

   function new();
      capacity = lrukv_pkg::CAP_RESET;
      mismatches = 0;
   endfunction

   function void write_capacity(logic [lrukv_pkg::CAP_W-1:0] cap);
      capacity = cap;
   endfunction

   function int fill_limit();
      int c;
      c = int'(capacity);
      if (c < 1) c = 1;
      if (c > lrukv_pkg::ENTRIES_DEFAULT) c = lrukv_pkg::ENTRIES_DEFAULT;
      return c;
   endfunction

   function int find_key(logic [lrukv_pkg::KEY_W-1:0] key);
      for (int i = 0; i < recency_list.size(); i++) begin
         if (recency_list[i].key == key) return i;
      end
      return -1;
   endfunction

   function void note_request(logic kind, logic [lrukv_pkg::KEY_W-1:0] key,
                              logic [lrukv_pkg::DATA_W-1:0] value);
      int pos;
      slot_t entry;
      read_t rd;
      pos = find_key(key);
      if (kind == lrukv_pkg::REQ_GET) begin
         if (pos >= 0) begin
            entry = recency_list[pos];
            recency_list.delete(pos);
            recency_list.insert(0, entry);
            rd.hit = 1'b1;
            rd.value = entry.data;
         end else begin
            rd.hit = 1'b0;
            rd.value = lrukv_pkg::MISS_VALUE;
         end
         expected_reads.push_back(rd);
      end else begin
         if (pos >= 0) recency_list.delete(pos);
         while (recency_list.size() >= fill_limit())
            recency_list.delete(recency_list.size() - 1);
         entry.key = key;
         entry.data = value;
         recency_list.insert(0, entry);
      end
   endfunction

   task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch: %s got %h want %h", what, got, want);
      mismatches++;
   endtask

   task check_response(logic hit, logic [lrukv_pkg::DATA_W-1:0] value);
      read_t want;
      if (expected_reads.size() == 0) begin
         report_mismatch("response with no get waiting, read_value", value, 32'h0);
         return;
      end
      want = expected_reads.pop_front();
      if (hit !== want.hit) report_mismatch("hit", 32'(hit), 32'(want.hit));
      if (value !== want.value) report_mismatch("read_value", value, want.value);
   endtask
endclass

module lru_key_value_cache_top_test;
   import lrukv_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 40;
   localparam int POOL_SIZE = 24;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_type = REQ_GET;
   logic signed [KEY_W-1:0] req_key = '0;
   logic signed [DATA_W-1:0] req_value = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_hit;
   logic signed [DATA_W-1:0] rsp_read_value;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CAP_W-1:0] csr_capacity = CAP_RESET;

   cache_scoreboard sb = new();
   bit idling_on = 1'b1;
   bit long_hold_request = 1'b0;
   int cycle_count = 0;
   logic [KEY_W-1:0] key_pool[POOL_SIZE];

   lru_key_value_cache_top uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_type(req_type),
      .req_key(req_key),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_hit(rsp_hit),
      .rsp_read_value(rsp_read_value),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_capacity(csr_capacity)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: failure");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) sb.check_response(rsp_hit, rsp_read_value);
         if (req_valid && !req_stall) sb.note_request(req_type, req_key, req_value);
         if (csr_valid && csr_ready) sb.write_capacity(csr_capacity);
      end
   end

   initial begin
      int held;
      forever begin
         @(posedge clock);
         if (long_hold_request) begin
            rsp_stall <= 1'b1;
            for (held = 0; held < HOLD_CYCLES; held++) @(posedge clock);
            long_hold_request = 1'b0;
            rsp_stall <= 1'b0;
         end else if (idling_on && $urandom_range(0, 4) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 4)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_item(logic kind, logic [KEY_W-1:0] key, logic [DATA_W-1:0] value);
      req_type <= kind;
      req_key <= key;
      req_value <= value;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_reads.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic program_capacity(logic [CAP_W-1:0] cap);
      wait_idle();
      csr_capacity <= cap;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [KEY_W-1:0] pick_key();
      if ($urandom_range(0, 3) != 0) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
      return $urandom;
   endfunction

   function automatic logic [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 11))
         0: return 32'hFFFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h7FFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   task automatic run_random_items(int count, int set_pct);
      for (int i = 0; i < count; i++) begin
         send_item(($urandom_range(0, 99) < set_pct) ? REQ_SET : REQ_GET,
                   pick_key(), pick_value());
      end
   endtask

   initial begin
      key_pool[0] = 32'h0000_0000;
      key_pool[1] = 32'hFFFF_FFFF;
      key_pool[2] = 32'h8000_0000;
      key_pool[3] = 32'h7FFF_FFFF;
      for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty store, then extremes of key and value
      send_item(REQ_GET, 32'h0000_0000, 32'h0000_0000);
      send_item(REQ_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(REQ_SET, 32'h7FFF_FFFF, 32'h8000_0000);
      send_item(REQ_SET, 32'h8000_0000, 32'h7FFF_FFFF);
      send_item(REQ_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(REQ_SET, 32'h0000_0000, 32'h0000_0000);
      send_item(REQ_GET, 32'hFFFF_FFFF, 32'h0000_0000);
      send_item(REQ_GET, 32'h8000_0000, 32'hFFFF_FFFF);
      send_item(REQ_GET, 32'h7FFF_FFFF, 32'h0000_0000);
      // update of a present key
      send_item(REQ_SET, 32'hFFFF_FFFF, 32'h1234_5678);
      send_item(REQ_GET, 32'hFFFF_FFFF, 32'h0000_0000);
      send_item(REQ_GET, 32'h0000_0000, 32'h0000_0000);
      send_item(REQ_GET, 32'h0000_0001, 32'h0000_0000);

      // capacity below the fill: old entries stay readable until the next set
      program_capacity(5'd2);
      send_item(REQ_GET, 32'h8000_0000, 32'h0000_0000);
      send_item(REQ_GET, 32'h7FFF_FFFF, 32'h0000_0000);
      send_item(REQ_SET, 32'h0000_0055, 32'hAAAA_AAAA);
      send_item(REQ_GET, 32'h0000_0055, 32'h0000_0000);
      send_item(REQ_GET, 32'h0000_0000, 32'h0000_0000);
      send_item(REQ_GET, 32'h7FFF_FFFF, 32'h0000_0000);

      // zero acts as one
      program_capacity(5'd0);
      send_item(REQ_SET, 32'h0000_0010, 32'h0000_0001);
      send_item(REQ_SET, 32'h0000_0020, 32'h0000_0002);
      send_item(REQ_GET, 32'h0000_0010, 32'h0000_0000);
      send_item(REQ_GET, 32'h0000_0020, 32'h0000_0000);
      send_item(REQ_SET, 32'h0000_0020, 32'h0000_0003);
      send_item(REQ_GET, 32'h0000_0020, 32'h0000_0000);

      program_capacity(5'd31);
      run_random_items(50, 60);
      program_capacity(5'd1);
      run_random_items(40, 50);
      program_capacity(5'd3);
      run_random_items(45, 50);
      program_capacity(5'd16);
      run_random_items(50, 55);

      // receiver holds off while the sender keeps offering
      program_capacity(5'd8);
      long_hold_request = 1'b1;
      run_random_items(45, 40);

      program_capacity(5'd17);
      run_random_items(45, 55);
      program_capacity(5'd0);
      run_random_items(40, 50);
      program_capacity(5'd2);
      run_random_items(40, 50);

      wait_idle();
      idling_on = 1'b0;
      program_capacity(5'd16);
      run_random_items(60, 50);

      wait_idle();
      repeat (5) @(posedge clock);
      if (sb.mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end
endmodule
